/* rtl/mm4_pkg.sv */
`timescale 1ns / 1ps

package mm4_pkg;

	// defaults for the top-level parameters
	localparam int DIM_DEF  = 4;
	localparam int FRAC_DEF = 16;

	// fixed element format
	localparam int ELEM_W = 32;

	// one element of an A row travelling down the cell chain
	typedef struct packed {
		logic                     valid;
		logic                     first;
		logic                     last;
		logic signed [ELEM_W-1:0] a;
	} mm4_beat_t;

	// finished product element held in a cell
	typedef struct packed {
		logic              valid;
		logic              ovf;
		logic [ELEM_W-1:0] res;
	} mm4_res_t;

endpackage

/* rtl/matrix_multiply_4x4_unit.sv */
`timescale 1ns / 1ps
// channel   dir  tdata                                  tuser     tlast
// s_axis    in   elem_0..elem_(DIM-1), 32b each         -         -
// m_axis    out  res_0..res_(DIM-1) 32b each, row_index overflow  last row
//
// a pair is 2*DIM input beats (A rows then B rows), one per cycle while idle
// then each product row passes DIM beats through the multiplier, an accumulate and a round
// stage, the chain skew through the beat registers of the cells, and the output register;
// the first row issues once busy is set by the last B row, each next one when the cells
// hand the previous row to the output register
// s_axis_tready is low from the last B row until the last product row is
// registered; a stalled output holds the next finished row inside the cells
// arst_n clears all control; stores and data registers are not reset

module matrix_multiply_4x4_unit import mm4_pkg::*; #(
	parameter int DIM       = DIM_DEF,
	parameter int FRAC_BITS = FRAC_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// elem_0 .. elem_(DIM-1), lowest first
	input  logic [((DIM * ELEM_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// res_0 .. res_(DIM-1), row_index, zero pad
	output logic [((DIM * ELEM_W + $clog2(DIM) + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// overflow
	output logic                m_axis_tuser,
	output logic                m_axis_tlast
);

	localparam int ROW_W = $clog2(DIM);
	localparam int CNT_W = $clog2(2 * DIM);
	localparam int ISS_W = $clog2(DIM + 1);

	logic signed [ELEM_W-1:0] in_row [DIM];
	logic                     in_acc;
	logic                     load_a;
	logic                     load_b;

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             in_flight_q;
	logic             pend_q;
	logic [ISS_W-1:0] issued_q;
	logic [ROW_W-1:0] done_row_q;

	mm4_beat_t chain [DIM];
	mm4_res_t  cell_res [DIM];

	logic comp;
	logic out_free;
	logic load_out;
	logic issue;
	logic row_ovf;

	logic [ELEM_W-1:0] out_res_q [DIM];
	logic [ROW_W-1:0]  out_row_q;
	logic              out_last_q;
	logic              out_ovf_q;
	logic              m_valid_q;

	// ---- input side
	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			in_row[j] = s_axis_tdata[j*ELEM_W +: ELEM_W];
		end
	end

	assign s_axis_tready = !busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load_a        = in_acc && (cnt_q < CNT_W'(DIM));
	assign load_b        = in_acc && !(cnt_q < CNT_W'(DIM));

	// ---- row sequencing
	// last cell finishing a row means every cell holds its element of that row
	assign comp     = cell_res[DIM-1].valid;
	assign out_free = !m_valid_q || m_axis_tready;
	assign load_out = (comp || pend_q) && out_free;
	// next row may enter once the previous one leaves the cells
	assign issue    = busy_q && !pend_q && (issued_q != ISS_W'(DIM))
	                  && (!in_flight_q || (comp && out_free));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			in_flight_q <= 1'b0;
			pend_q      <= 1'b0;
			issued_q    <= '0;
			done_row_q  <= '0;
		end else begin
			if (in_acc) begin
				if (cnt_q == CNT_W'(2 * DIM - 1)) begin
					cnt_q    <= '0;
					busy_q   <= 1'b1;
					issued_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (issue) begin
				in_flight_q <= 1'b1;
				issued_q    <= issued_q + 1'b1;
			end else if (comp) begin
				in_flight_q <= 1'b0;
			end
			if (comp && !out_free) begin
				pend_q <= 1'b1;
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				if (done_row_q == ROW_W'(DIM - 1)) begin
					done_row_q <= '0;
					busy_q     <= 1'b0;
				end else begin
					done_row_q <= done_row_q + 1'b1;
				end
			end
		end
	end

	// ---- A rows and feed into the chain
	mm4_feed #(
		.DIM (DIM)
	) u_feed (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_a),
		.load_row (in_row),
		.issue    (issue),
		.beat     (chain[0])
	);

	// ---- cell chain, one product column per cell
	for (genvar j = 0; j < DIM; j++) begin : g_cell
		if (j < DIM - 1) begin : g_mid
			mm4_cell #(
				.DIM       (DIM),
				.FRAC_BITS (FRAC_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (load_b),
				.load_elem (in_row[j]),
				.beat_in   (chain[j]),
				.beat_out  (chain[j+1]),
				.result    (cell_res[j])
			);
		end else begin : g_end
			mm4_cell #(
				.DIM       (DIM),
				.FRAC_BITS (FRAC_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (load_b),
				.load_elem (in_row[j]),
				.beat_in   (chain[j]),
				.beat_out  (),
				.result    (cell_res[j])
			);
		end
	end

	always_comb begin
		row_ovf = 1'b0;
		for (int j = 0; j < DIM; j++) begin
			row_ovf = row_ovf | cell_res[j].ovf;
		end
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int j = 0; j < DIM; j++) begin
				out_res_q[j] <= cell_res[j].res;
			end
			out_row_q  <= done_row_q;
			out_last_q <= (done_row_q == ROW_W'(DIM - 1));
			out_ovf_q  <= row_ovf;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int j = 0; j < DIM; j++) begin
			m_axis_tdata[j*ELEM_W +: ELEM_W] = out_res_q[j];
		end
		m_axis_tdata[DIM*ELEM_W +: ROW_W] = out_row_q;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_ovf_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/mm4_feed.sv */
`timescale 1ns / 1ps

module mm4_feed import mm4_pkg::*; #(
	parameter int DIM = DIM_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic signed [ELEM_W-1:0] load_row [DIM],
	input  logic                     issue,
	output mm4_beat_t                beat
);

	localparam int KW = $clog2(DIM);

	logic signed [ELEM_W-1:0] a_rows_q [DIM][DIM];
	logic signed [ELEM_W-1:0] sh_q [DIM];
	logic [KW-1:0]            k_q;
	logic                     active_q;

	// row store is a shift line; issue rotates row 0 to the tail
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < DIM - 1; i++) begin
				a_rows_q[i] <= a_rows_q[i+1];
			end
			a_rows_q[DIM-1] <= load_row;
		end else if (issue) begin
			sh_q <= a_rows_q[0];
			for (int i = 0; i < DIM - 1; i++) begin
				a_rows_q[i] <= a_rows_q[i+1];
			end
			a_rows_q[DIM-1] <= a_rows_q[0];
		end else if (active_q) begin
			for (int i = 0; i < DIM - 1; i++) begin
				sh_q[i] <= sh_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else if (issue) begin
			active_q <= 1'b1;
			k_q      <= '0;
		end else if (active_q) begin
			if (k_q == KW'(DIM - 1)) begin
				active_q <= 1'b0;
			end
			k_q <= k_q + 1'b1;
		end
	end

	assign beat.valid = active_q;
	assign beat.first = (k_q == '0);
	assign beat.last  = (k_q == KW'(DIM - 1));
	assign beat.a     = sh_q[0];

endmodule

/* rtl/mm4_cell.sv */
`timescale 1ns / 1ps

module mm4_cell import mm4_pkg::*; #(
	parameter int DIM       = DIM_DEF,
	parameter int FRAC_BITS = FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic signed [ELEM_W-1:0] load_elem,
	input  mm4_beat_t                beat_in,
	output mm4_beat_t                beat_out,
	output mm4_res_t                 result
);

	localparam int ACC_W = 2 * ELEM_W + $clog2(DIM) + 1;
	// half an lsb of the result, seeds the accumulator
	localparam logic signed [ACC_W-1:0] RND = ACC_W'((ACC_W'(1) << FRAC_BITS) >> 1);

	logic signed [ELEM_W-1:0]   bcol_q [DIM];
	mm4_beat_t                  beat_q;
	logic signed [2*ELEM_W-1:0] prod_s1;
	logic                       v_s1;
	logic                       first_s1;
	logic                       last_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       fin_s2;
	logic signed [ACC_W-1:0]    shifted;
	logic                       fits;
	logic                       res_valid_q;
	logic                       res_ovf_q;
	logic [ELEM_W-1:0]          res_data_q;

	// column of B: shift line on load, rotates once per consumed beat
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < DIM - 1; i++) begin
				bcol_q[i] <= bcol_q[i+1];
			end
			bcol_q[DIM-1] <= load_elem;
		end else if (beat_in.valid) begin
			for (int i = 0; i < DIM - 1; i++) begin
				bcol_q[i] <= bcol_q[i+1];
			end
			bcol_q[DIM-1] <= bcol_q[0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= beat_in.a * bcol_q[0];
		if (v_s1) begin
			acc_q <= (first_s1 ? RND : acc_q) + ACC_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q   <= '0;
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			fin_s2   <= 1'b0;
		end else begin
			beat_q   <= beat_in;
			v_s1     <= beat_in.valid;
			first_s1 <= beat_in.first;
			last_s1  <= beat_in.last;
			fin_s2   <= v_s1 && last_s1;
		end
	end

	// drop fraction bits, saturate to 32 bits
	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		fits    = (&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= fin_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_s2) begin
			res_ovf_q <= !fits;
			if (fits) begin
				res_data_q <= shifted[ELEM_W-1:0];
			end else if (shifted[ACC_W-1]) begin
				res_data_q <= {1'b1, {(ELEM_W-1){1'b0}}};
			end else begin
				res_data_q <= {1'b0, {(ELEM_W-1){1'b1}}};
			end
		end
	end

	assign beat_out     = beat_q;
	assign result.valid = res_valid_q;
	assign result.ovf   = res_ovf_q;
	assign result.res   = res_data_q;

endmodule
